// File: hdl/ctlp_pkg.sv
// ============================================================================
// ctlp_pkg - shared types, codes and tables for the option parser
// Phase and result codes, result and state records, known-option lengths
// and the field layout of the known options.
// ============================================================================
package ctlp_pkg;

    localparam logic [6:0] TYPE_MTU   = 7'd1;
    localparam logic [6:0] TYPE_FLUSH = 7'd2;
    localparam logic [6:0] TYPE_QOS   = 7'd3;
    localparam logic [6:0] TYPE_FEC   = 7'd4;
    localparam logic [6:0] TYPE_FCS   = 7'd5;

    localparam logic [7:0] LEN_MTU   = 8'd2;
    localparam logic [7:0] LEN_FLUSH = 8'd2;
    localparam logic [7:0] LEN_QOS   = 8'd22;
    localparam logic [7:0] LEN_FEC   = 8'd9;
    localparam logic [7:0] LEN_FCS   = 8'd1;

    localparam int HINT_BIT = 7;

    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    localparam logic [1:0] KIND_FIELD   = 2'd0;
    localparam logic [1:0] KIND_UNKNOWN = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    localparam logic [3:0] FID_MTU       = 4'd0;
    localparam logic [3:0] FID_FLUSH     = 4'd1;
    localparam logic [3:0] FID_QOS_TYPE  = 4'd2;
    localparam logic [3:0] FID_QOS_RATE  = 4'd3;
    localparam logic [3:0] FID_FEC_MODE  = 4'd8;
    localparam logic [3:0] FID_FEC_WIN   = 4'd9;
    localparam logic [3:0] FID_FEC_MAXTX = 4'd10;
    localparam logic [3:0] FID_FEC_RETX  = 4'd11;
    localparam logic [3:0] FID_FEC_MON   = 4'd12;
    localparam logic [3:0] FID_FEC_MPS   = 4'd13;

    localparam int OUTQ_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  field_id;
        logic [31:0] value;
        logic [7:0]  option_type;
        logic [7:0]  option_length;
        logic [1:0]  status;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]  count;
        result_t     first;
        result_t     second;
    } push_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [7:0]  cur_type;
        logic [7:0]  decl_len;
        logic [7:0]  pos;
        logic [31:0] acc;
        logic        malformed;
        logic        unknown;
    } state_t;

    typedef struct packed {
        logic        hit;
        logic        last;
        logic [1:0]  k;
        logic [3:0]  id;
    } fld_t;

    function automatic logic is_known(input logic [6:0] base);
        return (base >= TYPE_MTU) && (base <= TYPE_FCS);
    endfunction

    function automatic logic [7:0] required_len(input logic [6:0] base);
        logic [7:0] r;
        r = '0;
        unique case (base)
            TYPE_MTU:   r = LEN_MTU;
            TYPE_FLUSH: r = LEN_FLUSH;
            TYPE_QOS:   r = LEN_QOS;
            TYPE_FEC:   r = LEN_FEC;
            TYPE_FCS:   r = LEN_FCS;
            default:    r = '0;
        endcase
        return r;
    endfunction

    function automatic fld_t field_lookup(input logic [6:0] base, input logic [7:0] pos);
        fld_t       f;
        logic [7:0] off;
        f   = '0;
        off = pos - 8'd2;
        unique case (base)
            TYPE_MTU, TYPE_FLUSH:
            begin
                if (pos <= 8'd1)
                begin
                    f.hit  = 1'b1;
                    f.k    = pos[1:0];
                    f.last = pos[0];
                    f.id   = (base == TYPE_MTU) ? FID_MTU : FID_FLUSH;
                end
            end
            TYPE_QOS:
            begin
                if (pos == 8'd1)
                begin
                    f.hit  = 1'b1;
                    f.last = 1'b1;
                    f.id   = FID_QOS_TYPE;
                end
                else if (pos >= 8'd2 && pos <= 8'd21)
                begin
                    f.hit  = 1'b1;
                    f.k    = off[1:0];
                    f.last = (off[1:0] == 2'd3);
                    f.id   = FID_QOS_RATE + {1'b0, off[4:2]};
                end
            end
            TYPE_FEC:
            begin
                unique case (pos)
                    8'd0:    f = '{hit: 1'b1, last: 1'b1, k: 2'd0, id: FID_FEC_MODE};
                    8'd1:    f = '{hit: 1'b1, last: 1'b1, k: 2'd0, id: FID_FEC_WIN};
                    8'd2:    f = '{hit: 1'b1, last: 1'b1, k: 2'd0, id: FID_FEC_MAXTX};
                    8'd3:    f = '{hit: 1'b1, last: 1'b0, k: 2'd0, id: FID_FEC_RETX};
                    8'd4:    f = '{hit: 1'b1, last: 1'b1, k: 2'd1, id: FID_FEC_RETX};
                    8'd5:    f = '{hit: 1'b1, last: 1'b0, k: 2'd0, id: FID_FEC_MON};
                    8'd6:    f = '{hit: 1'b1, last: 1'b1, k: 2'd1, id: FID_FEC_MON};
                    8'd7:    f = '{hit: 1'b1, last: 1'b0, k: 2'd0, id: FID_FEC_MPS};
                    8'd8:    f = '{hit: 1'b1, last: 1'b1, k: 2'd1, id: FID_FEC_MPS};
                    default: f = '0;
                endcase
            end
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// File: hdl/ctlp_decode.sv
// ============================================================================
// ctlp_decode - per-beat option decode
// Works out the next parser state and up to two results for one beat.
// ============================================================================
module ctlp_decode (
    input  ctlp_pkg::state_t st,
    input  logic [1:0]       mode,
    input  logic [7:0]       opt_byte,
    output ctlp_pkg::state_t st_next,
    output ctlp_pkg::push_t  push
);
    import ctlp_pkg::*;

    logic [6:0] base;
    logic       report_unknown;
    fld_t       fld;
    logic [7:0] req;
    logic [8:0] pos_inc;
    logic       ends;
    logic       fin_malformed;
    logic       have_a;
    result_t    res_a;
    result_t    res_s;
    logic [4:0] shamt;

    assign base           = st.cur_type[6:0];
    assign report_unknown = !is_known(base) && !st.cur_type[HINT_BIT];
    assign fld            = field_lookup(base, st.pos);
    assign req            = required_len(opt_byte[6:0] == 7'd0 ? base : base);
    assign pos_inc        = {1'b0, st.pos} + 9'd1;
    assign ends           = (mode != 2'd0);
    assign shamt          = {fld.k, 3'b000};

    always_comb
    begin
        st_next       = st;
        have_a        = 1'b0;
        res_a         = '0;
        res_s         = '0;
        fin_malformed = 1'b0;
        if (!mode[1] && !st.malformed)
        begin
            unique case (st.phase)
                PH_TYPE:
                begin
                    st_next.cur_type = opt_byte;
                    st_next.phase    = PH_LEN;
                end
                PH_LEN:
                begin
                    st_next.decl_len = opt_byte;
                    st_next.pos      = '0;
                    st_next.acc      = '0;
                    if (is_known(base) && opt_byte != req)
                    begin
                        st_next.malformed = 1'b1;
                    end
                    else if (opt_byte == 8'd0)
                    begin
                        if (report_unknown)
                        begin
                            st_next.unknown   = 1'b1;
                            have_a            = 1'b1;
                            res_a.kind        = KIND_UNKNOWN;
                            res_a.option_type = st.cur_type;
                        end
                        st_next.phase = PH_TYPE;
                    end
                    else
                    begin
                        st_next.phase = PH_DATA;
                    end
                end
                default:
                begin
                    if (fld.hit)
                    begin
                        if (fld.k == 2'd0)
                            st_next.acc = {24'd0, opt_byte};
                        else
                            st_next.acc = st.acc | ({24'd0, opt_byte} << shamt);
                        if (fld.last)
                        begin
                            have_a         = 1'b1;
                            res_a.kind     = KIND_FIELD;
                            res_a.field_id = fld.id;
                            res_a.value    = st_next.acc;
                        end
                    end
                    st_next.pos = pos_inc[7:0];
                    if (pos_inc >= {1'b0, st.decl_len})
                    begin
                        if (report_unknown)
                        begin
                            st_next.unknown     = 1'b1;
                            have_a              = 1'b1;
                            res_a.kind          = KIND_UNKNOWN;
                            res_a.option_type   = st.cur_type;
                            res_a.option_length = st.decl_len;
                        end
                        st_next.phase = PH_TYPE;
                        st_next.pos   = '0;
                    end
                end
            endcase
        end
        if (ends)
        begin
            fin_malformed = st_next.malformed || (st_next.phase != PH_TYPE);
            res_s.kind    = KIND_STATUS;
            res_s.last    = 1'b1;
            res_s.status  = fin_malformed ? ST_MALFORMED :
                            (st_next.unknown ? ST_UNKNOWN : ST_ACCEPTED);
            st_next       = '0;
        end
    end

    assign push.first  = have_a ? res_a : res_s;
    assign push.second = res_s;
    assign push.count  = {1'b0, have_a} + {1'b0, ends};

endmodule

// File: hdl/ctlp_outq.sv
// ============================================================================
// ctlp_outq - result queue
// Small FIFO taking up to two results a cycle and giving one a cycle.
// ============================================================================
module ctlp_outq #(
    parameter int DEPTH = ctlp_pkg::OUTQ_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_en,
    input  ctlp_pkg::push_t   push,
    input  logic              pop,
    output logic              out_valid,
    output ctlp_pkg::result_t out_res,
    output logic              room
);
    import ctlp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t             mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [1:0]          push_n;
    logic [CNT_W:0]      space;

    assign push_n      = push_en ? push.count : 2'd0;
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    assign space       = (CNT_W+1)'(DEPTH) - {1'b0, count_reg};
    assign room        = (space >= (CNT_W+1)'(2));
    assign out_valid   = (count_reg != '0);
    assign out_res     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push_n == 2'd2)
            mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/config_option_tlv_parser_core.sv
// ============================================================================
// config_option_tlv_parser_core - configuration option TLV parser
// Parses the option area of a configure command one byte a beat.
// ============================================================================
// Input channel s_*: one beat per option byte, s_tuser carries the mode
// (byte, byte that ends the command, end without byte).
// Output channel m_*: decoded fields, unknown option reports and the end
// status; m_tlast marks the status beat that closes a command.
// A taken beat is held in the input register and decoded from there; its
// results go into the output queue, whose head is offered on m_*.
// One beat a cycle is taken for as long as the results drain one a cycle;
// a beat giving two results (field or report plus status) puts both into
// the queue. Rate is set by the output queue: the input register moves
// on only when the queue has room for two results.
// Reset empties the input register and the queue and returns the parser
// to the start of a command. While the receiver stalls, the queue fills
// and s_tready drops; nothing is lost or repeated.
// ============================================================================
module config_option_tlv_parser_core #(
    parameter int OUTQ_DEPTH = ctlp_pkg::OUTQ_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // opt_byte
    input  logic [1:0]  s_tuser,    // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // field_id, value, option_type, option_length, status, pad
    output logic [1:0]  m_tuser,    // kind
    output logic        m_tlast     // last
);
    import ctlp_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [1:0] in_mode_reg;
    logic [7:0] in_byte_reg;
    state_t     state_reg;
    state_t     state_next;
    push_t      push;
    result_t    out_res;
    logic       room;
    logic       advance;
    logic       pop;

    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || advance;
    assign pop      = m_tvalid && m_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    ctlp_decode u_decode (
        .st       (state_reg),
        .mode     (in_mode_reg),
        .opt_byte (in_byte_reg),
        .st_next  (state_next),
        .push     (push)
    );

    ctlp_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (advance),
        .push      (push),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .room      (room)
    );

    assign m_tdata = {2'b00, out_res.status, out_res.option_length, out_res.option_type,
                      out_res.value, out_res.field_id};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

`ifndef SYNTHESIS
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == KIND_STATUS) == m_tlast))
        else $error("status beat and tlast disagree");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_mode_reg)
            && $stable(in_byte_reg) && $stable(state_reg))
        else $error("held beat or parser state changed");

    a_no_output_after_malformed: assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg.malformed |-> (push.count == 2'd0) || (push.count == 2'd1
            && push.first.kind == KIND_STATUS))
        else $error("result other than status after malformed option");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top - self-checking bench for config_option_tlv_parser_core
// Feeds hand-made and random option areas into the parser one byte a beat.
// A behavioural model predicts the decoded fields, unknown option reports
// and end statuses, and every output beat is checked against it in order.
// The run goes through phases with source gaps and sink back-pressure.
// ============================================================================
module tb_top;
    import ctlp_pkg::*;

    localparam logic [1:0] MODE_BYTE     = 2'd0;
    localparam logic [1:0] MODE_BYTE_END = 2'd1;
    localparam logic [1:0] MODE_END      = 2'd2;
    localparam logic [1:0] MODE_END_ALT  = 2'd3;

    localparam logic [8:0] NO_RULE = 9'h100;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 40;
    localparam int PHASE_BEATS     = 282;
    localparam int MAX_REPORTS     = 10;
    localparam int TAIL_CYCLES     = 20;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
    } beat_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] k;
        logic [2:0] nbytes;
        logic [3:0] id;
    } slot_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;    // opt_byte
    logic [1:0]  s_tuser  = 2'd0;     // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;             // field_id, value, option_type, option_length, status, pad
    logic [1:0]  m_tuser;             // kind
    logic        m_tlast;

    beat_t   byte_queue[$];
    result_t expected_results[$];
    state_t  parse_st = '0;
    beat_t   drv_beat;
    result_t seen;
    result_t want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int beats_queued   = 0;
    int beats_in       = 0;
    int beats_out      = 0;
    int failures       = 0;
    int n_fields       = 0;
    int n_reports      = 0;
    int n_accepted     = 0;
    int n_unknown_st   = 0;
    int n_malformed    = 0;
    int hold_cnt       = 0;
    logic hold_done    = 1'b0;
    int quiet_cycles   = 0;

    config_option_tlv_parser_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // option parser model
    // ------------------------------------------------------------------
    function automatic logic [8:0] rule_length(input logic [6:0] base);
        case (base)
            TYPE_MTU:   return {1'b0, LEN_MTU};
            TYPE_FLUSH: return {1'b0, LEN_FLUSH};
            TYPE_QOS:   return {1'b0, LEN_QOS};
            TYPE_FEC:   return {1'b0, LEN_FEC};
            TYPE_FCS:   return {1'b0, LEN_FCS};
            default:    return NO_RULE;
        endcase
    endfunction

    function automatic logic reports_unknown(input logic [7:0] t);
        return (rule_length(t[6:0]) == NO_RULE) && !t[HINT_BIT];
    endfunction

    // where a data byte lands in the little-endian fields of its option
    function automatic slot_t locate_byte(input logic [6:0] base, input logic [7:0] pos);
        slot_t      s;
        logic [7:0] rel;
        s = '0;
        case (base)
            TYPE_MTU, TYPE_FLUSH:
            begin
                if (pos < 8'd2)
                begin
                    s.hit    = 1'b1;
                    s.k      = pos[1:0];
                    s.nbytes = 3'd2;
                    s.id     = (base == TYPE_MTU) ? FID_MTU : FID_FLUSH;
                end
            end
            TYPE_QOS:
            begin
                // byte 0 is the flags byte, not reported
                if (pos == 8'd1)
                begin
                    s.hit    = 1'b1;
                    s.nbytes = 3'd1;
                    s.id     = FID_QOS_TYPE;
                end
                else if (pos >= 8'd2 && pos <= 8'd21)
                begin
                    rel      = pos - 8'd2;
                    s.hit    = 1'b1;
                    s.k      = rel[1:0];
                    s.nbytes = 3'd4;
                    s.id     = FID_QOS_RATE + {1'b0, rel[4:2]};
                end
            end
            TYPE_FEC:
            begin
                if (pos <= 8'd2)
                begin
                    s.hit    = 1'b1;
                    s.nbytes = 3'd1;
                    s.id     = FID_FEC_MODE + pos[3:0];
                end
                else if (pos <= 8'd8)
                begin
                    rel      = pos - 8'd3;
                    s.hit    = 1'b1;
                    s.k      = {1'b0, rel[0]};
                    s.nbytes = 3'd2;
                    s.id     = FID_FEC_RETX + {1'b0, rel[3:1]};
                end
            end
            default:
            begin
                s = '0;
            end
        endcase
        return s;
    endfunction

    task automatic expect_result(input logic [1:0] kind, input logic [3:0] id,
                                 input logic [31:0] value, input logic [7:0] otype,
                                 input logic [7:0] olen, input logic [1:0] status,
                                 input logic last);
        result_t r;
        r.kind          = kind;
        r.field_id      = id;
        r.value         = value;
        r.option_type   = otype;
        r.option_length = olen;
        r.status        = status;
        r.last          = last;
        expected_results.push_back(r);
    endtask

    task automatic predict_option_beat(input logic [1:0] mode, input logic [7:0] data);
        slot_t      sl;
        logic [8:0] rule;
        logic [1:0] st;
        if (mode <= MODE_BYTE_END && !parse_st.malformed)
        begin
            if (parse_st.phase == PH_TYPE)
            begin
                parse_st.cur_type = data;
                parse_st.phase    = PH_LEN;
            end
            else if (parse_st.phase == PH_LEN)
            begin
                rule              = rule_length(parse_st.cur_type[6:0]);
                parse_st.decl_len = data;
                parse_st.pos      = '0;
                parse_st.acc      = '0;
                if (rule != NO_RULE && {1'b0, data} != rule)
                begin
                    parse_st.malformed = 1'b1;
                end
                else if (data == 8'd0)
                begin
                    if (reports_unknown(parse_st.cur_type))
                    begin
                        parse_st.unknown = 1'b1;
                        expect_result(KIND_UNKNOWN, '0, '0, parse_st.cur_type, '0, '0, 1'b0);
                    end
                    parse_st.phase = PH_TYPE;
                end
                else
                begin
                    parse_st.phase = PH_DATA;
                end
            end
            else
            begin
                sl = locate_byte(parse_st.cur_type[6:0], parse_st.pos);
                if (sl.hit)
                begin
                    if (sl.k == 2'd0)
                        parse_st.acc = {24'd0, data};
                    else
                        parse_st.acc = parse_st.acc | ({24'd0, data} << (8 * sl.k));
                    if (sl.k + 1 == sl.nbytes)
                        expect_result(KIND_FIELD, sl.id, parse_st.acc, '0, '0, '0, 1'b0);
                end
                parse_st.pos = parse_st.pos + 8'd1;
                if (parse_st.pos >= parse_st.decl_len)
                begin
                    if (reports_unknown(parse_st.cur_type))
                    begin
                        parse_st.unknown = 1'b1;
                        expect_result(KIND_UNKNOWN, '0, '0, parse_st.cur_type,
                                      parse_st.decl_len, '0, 1'b0);
                    end
                    parse_st.phase = PH_TYPE;
                    parse_st.pos   = '0;
                end
            end
        end
        if (mode != MODE_BYTE)
        begin
            // ending inside a header or data is malformed
            if (parse_st.phase != PH_TYPE)
                parse_st.malformed = 1'b1;
            st = parse_st.malformed ? ST_MALFORMED :
                 (parse_st.unknown ? ST_UNKNOWN : ST_ACCEPTED);
            expect_result(KIND_STATUS, '0, '0, '0, '0, st, 1'b1);
            parse_st       = '0;
            parse_st.phase = PH_TYPE;
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] mode, input logic [7:0] data);
        beat_t b;
        b.mode = mode;
        b.data = data;
        byte_queue.push_back(b);
        beats_queued++;
    endtask

    function automatic logic [7:0] random_octet();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // one command: mostly well-formed options, some unknown, wrong-length,
    // truncated or plain noise
    task automatic gen_command();
        logic [7:0] body[$];
        logic [7:0] opt[$];
        logic [6:0] base;
        logic       cut;
        int         n_opt, sel, len, rule, keep, i, j;
        cut = 1'b0;
        if ($urandom_range(0, 19) == 0)
        begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++)
                body.push_back(8'($urandom));
        end
        else
        begin
            n_opt = $urandom_range(0, 4);
            for (i = 0; i < n_opt && !cut; i++)
            begin
                sel = $urandom_range(0, 99);
                opt = {};
                if (sel < 70 || sel >= 85)
                begin
                    case ($urandom_range(0, 4))
                        0:       base = TYPE_MTU;
                        1:       base = TYPE_FLUSH;
                        2:       base = TYPE_QOS;
                        3:       base = TYPE_FEC;
                        default: base = TYPE_FCS;
                    endcase
                    len = int'(rule_length(base));
                end
                else
                begin
                    base = ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(6, 127));
                    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 6);
                end
                rule = len;
                if (sel >= 85 && sel < 92)
                begin
                    len = $urandom_range(0, 30);
                    if (len == rule)
                        len = len + 1;
                    rule = (len < 4) ? len : 4;
                    cut  = 1'b1;
                end
                opt.push_back({1'($urandom_range(0, 1)), base});
                opt.push_back(8'(len));
                for (j = 0; j < rule; j++)
                    opt.push_back(random_octet());
                if (sel >= 92)
                begin
                    keep = $urandom_range(1, opt.size() - 1);
                    for (j = 0; j < keep; j++)
                        body.push_back(opt[j]);
                    cut = 1'b1;
                end
                else
                begin
                    for (j = 0; j < opt.size(); j++)
                        body.push_back(opt[j]);
                end
            end
        end
        if (body.size() != 0 && $urandom_range(0, 1) == 1)
        begin
            for (i = 0; i < body.size() - 1; i++)
                send_beat(MODE_BYTE, body[i]);
            send_beat(MODE_BYTE_END, body[body.size() - 1]);
        end
        else
        begin
            for (i = 0; i < body.size(); i++)
                send_beat(MODE_BYTE, body[i]);
            send_beat(($urandom_range(0, 15) == 0) ? MODE_END_ALT : MODE_END, random_octet());
        end
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int n_beats);
        int target;
        @(negedge clk);
        send_idle_pct  <= src_pct;
        recv_stall_pct <= snk_pct;
        target = beats_queued + n_beats;
        while (beats_queued < target)
            gen_command();
        while (byte_queue.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_option_beat(s_tuser, s_tdata);
                beats_in <= beats_in + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    drv_beat = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= drv_beat.data;
                    s_tuser  <= drv_beat.mode;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sink side, with one long hold-off to back the parser up
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt != 0)
            begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end
            else if (!hold_done && beats_in >= HOLD_OFF_AFTER)
            begin
                hold_done <= 1'b1;
                hold_cnt  <= HOLD_OFF_CYCLES;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // result check
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.kind          = m_tuser;
            seen.field_id      = m_tdata[3:0];
            seen.value         = m_tdata[35:4];
            seen.option_type   = m_tdata[43:36];
            seen.option_length = m_tdata[51:44];
            seen.status        = m_tdata[53:52];
            seen.last          = m_tlast;
            beats_out <= beats_out + 1;
            case (seen.kind)
                KIND_FIELD:   n_fields++;
                KIND_UNKNOWN: n_reports++;
                KIND_STATUS:
                begin
                    if (seen.status == ST_ACCEPTED)
                        n_accepted++;
                    else if (seen.status == ST_UNKNOWN)
                        n_unknown_st++;
                    else
                        n_malformed++;
                end
                default: ;
            endcase
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result beat: kind %0d id %0d value %h type %h len %0d status %0d last %b",
                             seen.kind, seen.field_id, seen.value, seen.option_type,
                             seen.option_length, seen.status, seen.last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.kind !== seen.kind || want.field_id !== seen.field_id ||
                    want.value !== seen.value || want.option_type !== seen.option_type ||
                    want.option_length !== seen.option_length ||
                    want.status !== seen.status || want.last !== seen.last)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                    begin
                        $display("mismatch on result beat %0d", beats_out);
                        $display("  expected kind %0d id %0d value %h type %h len %0d status %0d last %b",
                                 want.kind, want.field_id, want.value, want.option_type,
                                 want.option_length, want.status, want.last);
                        $display("  actual   kind %0d id %0d value %h type %h len %0d status %0d last %b",
                                 seen.kind, seen.field_id, seen.value, seen.option_type,
                                 seen.option_length, seen.status, seen.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: no beat on either side for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("watchdog: no beat for %0d cycles", quiet_cycles);
                $display("[config_option_tlv_parser_core] ERROR");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty command
        send_beat(MODE_END, 8'h00);
        // MTU at its maximum, command closed on the last data byte
        send_beat(MODE_BYTE, {1'b0, TYPE_MTU});
        send_beat(MODE_BYTE, LEN_MTU);
        send_beat(MODE_BYTE, 8'hFF);
        send_beat(MODE_BYTE_END, 8'hFF);
        // unknown option of length zero, reported at its length byte
        send_beat(MODE_BYTE, 8'h06);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_END, 8'hFF);
        // hinted unknown and FCS are skipped; end code three
        send_beat(MODE_BYTE, 8'h86);
        send_beat(MODE_BYTE, 8'h01);
        send_beat(MODE_BYTE, 8'hAA);
        send_beat(MODE_BYTE, {1'b1, TYPE_FCS});
        send_beat(MODE_BYTE, LEN_FCS);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_END_ALT, 8'h5A);
        // wrong flush length, then an MTU that must be ignored
        send_beat(MODE_BYTE, {1'b0, TYPE_FLUSH});
        send_beat(MODE_BYTE, 8'h03);
        send_beat(MODE_BYTE, {1'b0, TYPE_MTU});
        send_beat(MODE_BYTE, LEN_MTU);
        send_beat(MODE_BYTE, 8'h00);
        send_beat(MODE_END, 8'h00);
        // overrun: command ends mid data
        send_beat(MODE_BYTE, {1'b0, TYPE_MTU});
        send_beat(MODE_BYTE, LEN_MTU);
        send_beat(MODE_BYTE_END, 8'h34);

        run_phase(0, 0, PHASE_BEATS);
        run_phase(71, 0, PHASE_BEATS);
        run_phase(0, 71, PHASE_BEATS);
        run_phase(20, 20, PHASE_BEATS);

        while (byte_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            failures += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("%0d option bytes in, %0d results out: %0d fields, %0d unknown reports, status accepted/unknown/malformed %0d/%0d/%0d",
                 beats_in, beats_out, n_fields, n_reports, n_accepted, n_unknown_st, n_malformed);
        $display("gaps: none, source 71%%, sink 71%%, both 20%%; one sink hold-off of %0d cycles; %0d failures",
                 HOLD_OFF_CYCLES, failures);
        if (failures == 0)
            $display("[config_option_tlv_parser_core] OK");
        else
            $display("[config_option_tlv_parser_core] ERROR");
        $finish;
    end

endmodule

// File: sim.f
hdl/ctlp_pkg.sv
hdl/ctlp_decode.sv
hdl/ctlp_outq.sv
hdl/config_option_tlv_parser_core.sv
bench/tb_top.sv
